// File: rtl/core/mtt_pkg.sv
// shared types and constants of the markup tag tokenizer
`timescale 1ns / 1ps

package mtt_pkg;

    // delimiter characters
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // command queue depth
    localparam int QDEPTH = 4;

    // result kinds
    typedef enum logic [2:0] {
        KIND_CONTENT  = 3'd0,
        KIND_START    = 3'd1,
        KIND_ATTR     = 3'd2,
        KIND_END_ATTR = 3'd3,
        KIND_END_TAG  = 3'd4,
        KIND_PI       = 3'd5,
        KIND_ERROR    = 3'd6
    } kind_t;

    // commands passed from front to back
    typedef enum logic [2:0] {
        OP_APPEND    = 3'd0,
        OP_CONTENT   = 3'd1,
        OP_START     = 3'd2,
        OP_ATTR      = 3'd3,
        OP_ATTR_END  = 3'd4,
        OP_TAG_CLOSE = 3'd5,
        OP_PI        = 3'd6,
        OP_ERROR     = 3'd7
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

    // queue status towards the front
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // parse modes of the front
    typedef enum logic [3:0] {
        MODE_CONTENT = 4'b0001,
        MODE_PI      = 4'b0010,
        MODE_TAG     = 4'b0100,
        MODE_ATTR    = 4'b1000
    } mode_t;

    // back sequencer states
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_BYTES  = 4'b0010,
        ST_SINGLE = 4'b0100,
        ST_EVENT  = 4'b1000
    } bstate_t;

endpackage

// File: rtl/core/mtt_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module mtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wen,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     ren,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/mtt_front.sv
// front end: accepts bytes, tracks parse mode and issues commands
`timescale 1ns / 1ps

module mtt_front import mtt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_stall,
    input  logic [7:0] in_byte,
    input  q_status_t  q_status,
    output logic       push,
    output cmd_t       push_cmd
);

    mode_t mode_reg, mode_next;
    logic  halted_reg, halted_next;
    logic  accept;
    logic  issue;
    op_t   op;

    // halted front swallows everything
    assign src_stall = !halted_reg && q_status.full;
    assign accept    = src_valid && !src_stall;

    // classify the byte against the current mode
    always_comb
    begin
        mode_next   = mode_reg;
        halted_next = halted_reg;
        issue       = 1'b1;
        op          = OP_APPEND;
        case (in_byte)
            CH_LT:
            begin
                if (mode_reg == MODE_CONTENT)
                begin
                    op        = OP_CONTENT;
                    mode_next = MODE_TAG;
                end
                else
                begin
                    issue = 1'b0;
                end
            end
            CH_QMARK:
            begin
                if (mode_reg == MODE_TAG)
                begin
                    issue     = 1'b0;
                    mode_next = MODE_PI;
                end
            end
            CH_SPACE:
            begin
                if (mode_reg == MODE_TAG)
                begin
                    op        = OP_START;
                    mode_next = MODE_ATTR;
                end
                else if (mode_reg == MODE_ATTR)
                begin
                    op = OP_ATTR;
                end
            end
            CH_GT:
            begin
                mode_next = MODE_CONTENT;
                case (mode_reg)
                    MODE_CONTENT:
                    begin
                        op          = OP_ERROR;
                        halted_next = 1'b1;
                    end
                    MODE_ATTR: op = OP_ATTR_END;
                    MODE_TAG:  op = OP_TAG_CLOSE;
                    default:   op = OP_PI;
                endcase
            end
            default:
            begin
                op = OP_APPEND;
            end
        endcase
        if (halted_reg)
        begin
            issue       = 1'b0;
            mode_next   = mode_reg;
            halted_next = 1'b1;
        end
    end

    assign push          = accept && issue;
    assign push_cmd.op   = op;
    assign push_cmd.data = in_byte;

    // mode and halt registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_CONTENT;
            halted_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            halted_reg <= halted_next;
        end
    end

endmodule

// File: rtl/core/mtt_queue.sv
// short command queue between front and back
`timescale 1ns / 1ps

module mtt_queue import mtt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head_cmd,
    output q_status_t status
);

    localparam int PW = $clog2(QDEPTH);

    cmd_t          slot_reg [QDEPTH];
    logic [PW-1:0] wptr_reg;
    logic [PW-1:0] rptr_reg;
    logic [PW:0]   count_reg;
    logic          do_push;
    logic          do_pop;

    assign status.full  = (count_reg == (PW+1)'(QDEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = slot_reg[rptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: rtl/core/mtt_back.sv
// back end: token buffer and result sequencer
`timescale 1ns / 1ps

module mtt_back import mtt_pkg::*; #(
    parameter int MAX_TOKEN = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head_cmd,
    input  logic       q_empty,
    output logic       pop,
    output logic       tok_valid,
    input  logic       tok_stall,
    output logic [2:0] token_kind,
    output logic [7:0] token_byte,
    output logic       byte_valid,
    output logic       token_last,
    output logic       run_last,
    output logic       truncated
);

    localparam int LW = $clog2(MAX_TOKEN + 1);
    localparam int AW = $clog2(MAX_TOKEN);

    bstate_t       state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic          slash_reg, slash_next;
    logic [LW-1:0] idx_reg, idx_next;
    kind_t         kind_reg, kind_next;
    kind_t         ev_kind_reg, ev_kind_next;
    logic          ev_after_reg, ev_after_next;

    logic          out_valid_reg, out_valid_next;
    kind_t         out_kind_reg, out_kind_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_bvalid_reg, out_bvalid_next;
    logic          out_tlast_reg, out_tlast_next;
    logic          out_rlast_reg, out_rlast_next;
    logic          out_trunc_reg, out_trunc_next;

    logic          out_free;
    logic          wen;
    logic          ren;
    logic [LW-1:0] raddr;
    logic [7:0]    rdata;
    logic [LW-1:0] idx_inc;
    logic          is_last;
    logic          tag_end;

    // op decode helpers
    kind_t         dec_kind;
    logic [LW-1:0] dec_start;
    logic          dec_event;

    assign out_free = !out_valid_reg || !tok_stall;
    assign idx_inc  = idx_reg + {{(LW-1){1'b0}}, 1'b1};
    assign is_last  = (idx_inc == len_reg);
    assign tag_end  = (len_reg != '0) && slash_reg;
    assign pop      = (state_reg == ST_IDLE) && !q_empty;
    assign wen      = pop && (head_cmd.op == OP_APPEND) && (len_reg < LW'(MAX_TOKEN));

    // token buffer
    mtt_ram #(
        .WIDTH (8),
        .DEPTH (MAX_TOKEN)
    ) u_buf (
        .clk   (clk),
        .wen   (wen),
        .waddr (len_reg[AW-1:0]),
        .wdata (head_cmd.data),
        .ren   (ren),
        .raddr (raddr[AW-1:0]),
        .rdata (rdata)
    );

    // kind, first position and trailing event per command
    always_comb
    begin
        dec_kind  = KIND_CONTENT;
        dec_start = '0;
        dec_event = 1'b0;
        case (head_cmd.op)
            OP_START:    dec_kind = KIND_START;
            OP_ATTR:     dec_kind = KIND_ATTR;
            OP_ATTR_END:
            begin
                dec_kind  = KIND_ATTR;
                dec_event = 1'b1;
            end
            OP_TAG_CLOSE:
            begin
                if (tag_end)
                begin
                    dec_kind  = KIND_END_TAG;
                    dec_start = {{(LW-1){1'b0}}, 1'b1};
                end
                else
                begin
                    dec_kind  = KIND_START;
                    dec_event = 1'b1;
                end
            end
            OP_PI:       dec_kind = KIND_PI;
            default:     dec_kind = KIND_CONTENT;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        ovf_next        = ovf_reg;
        slash_next      = slash_reg;
        idx_next        = idx_reg;
        kind_next       = kind_reg;
        ev_kind_next    = ev_kind_reg;
        ev_after_next   = ev_after_reg;
        ren             = 1'b0;
        raddr           = idx_inc;
        out_valid_next  = out_valid_reg && tok_stall;
        out_kind_next   = out_kind_reg;
        out_byte_next   = out_byte_reg;
        out_bvalid_next = out_bvalid_reg;
        out_tlast_next  = out_tlast_reg;
        out_rlast_next  = out_rlast_reg;
        out_trunc_next  = out_trunc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    case (head_cmd.op)
                        OP_APPEND:
                        begin
                            if (len_reg < LW'(MAX_TOKEN))
                            begin
                                len_next = len_reg + {{(LW-1){1'b0}}, 1'b1};
                                if (len_reg == '0)
                                begin
                                    slash_next = (head_cmd.data == CH_SLASH);
                                end
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_ERROR:
                        begin
                            ev_kind_next = KIND_ERROR;
                            state_next   = ST_EVENT;
                        end
                        default:
                        begin
                            kind_next     = dec_kind;
                            ev_after_next = dec_event;
                            ev_kind_next  = KIND_END_ATTR;
                            idx_next      = dec_start;
                            if (head_cmd.op == OP_CONTENT && len_reg == '0)
                            begin
                                // empty content is dropped
                                ovf_next = 1'b0;
                            end
                            else if (len_reg <= dec_start)
                            begin
                                state_next = ST_SINGLE;
                            end
                            else
                            begin
                                ren        = 1'b1;
                                raddr      = dec_start;
                                state_next = ST_BYTES;
                            end
                        end
                    endcase
                end
            end
            ST_BYTES:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = kind_reg;
                    out_byte_next   = rdata;
                    out_bvalid_next = 1'b1;
                    out_tlast_next  = is_last;
                    out_rlast_next  = is_last && !ev_after_reg;
                    out_trunc_next  = ovf_reg;
                    if (!is_last)
                    begin
                        idx_next = idx_inc;
                        ren      = 1'b1;
                    end
                    else if (ev_after_reg)
                    begin
                        state_next = ST_EVENT;
                    end
                    else
                    begin
                        len_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SINGLE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = kind_reg;
                    out_byte_next   = '0;
                    out_bvalid_next = 1'b0;
                    out_tlast_next  = 1'b1;
                    out_rlast_next  = !ev_after_reg;
                    out_trunc_next  = ovf_reg;
                    if (ev_after_reg)
                    begin
                        state_next = ST_EVENT;
                    end
                    else
                    begin
                        len_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EVENT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = ev_kind_reg;
                    out_byte_next   = '0;
                    out_bvalid_next = 1'b0;
                    out_tlast_next  = 1'b1;
                    out_rlast_next  = 1'b1;
                    out_trunc_next  = 1'b0;
                    len_next        = '0;
                    ovf_next        = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        slash_reg      <= slash_next;
        idx_reg        <= idx_next;
        kind_reg       <= kind_next;
        ev_kind_reg    <= ev_kind_next;
        ev_after_reg   <= ev_after_next;
        out_kind_reg   <= out_kind_next;
        out_byte_reg   <= out_byte_next;
        out_bvalid_reg <= out_bvalid_next;
        out_tlast_reg  <= out_tlast_next;
        out_rlast_reg  <= out_rlast_next;
        out_trunc_reg  <= out_trunc_next;
    end

    assign tok_valid  = out_valid_reg;
    assign token_kind = out_kind_reg;
    assign token_byte = out_byte_reg;
    assign byte_valid = out_bvalid_reg;
    assign token_last = out_tlast_reg;
    assign run_last   = out_rlast_reg;
    assign truncated  = out_trunc_reg;

    // length never passes the buffer size
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(MAX_TOKEN))
        else $error("token length beyond buffer");

    // overflow only once the buffer is full
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (len_reg == LW'(MAX_TOKEN)))
        else $error("overflow flag with room left");

    // byte streaming stays inside the held token
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BYTES) |-> (idx_reg < len_reg))
        else $error("read index past token end");

    // a run always ends on a token boundary
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_rlast_reg) |-> out_tlast_reg)
        else $error("run ends inside a token");

    // no command taken while a token is in flight
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE))
        else $error("pop outside idle");

endmodule

// File: rtl/core/markup_tag_tokenizer_core.sv
// top level of the markup tag tokenizer
//
//  transaction  valid      stall      payload
//  byte in      src_valid  src_stall  in_byte
//  token out    tok_valid  tok_stall  token_kind token_byte byte_valid
//                                     token_last run_last truncated
//
// an ordinary byte becomes one append command; the front keeps taking bytes
// while the four-entry command queue has room
// for a delimiter the back end does one buffer ram read per emitted byte,
// and a trailing event is emitted as a result of its own
// reset clears mode, halt, queue and token length; buffer contents need no reset
// output stall holds the result register and, once the queue fills, src_stall
`timescale 1ns / 1ps

module markup_tag_tokenizer_core import mtt_pkg::*; #(
    parameter int MAX_TOKEN = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_stall,
    input  logic [7:0] in_byte,
    output logic       tok_valid,
    input  logic       tok_stall,
    output logic [2:0] token_kind,
    output logic [7:0] token_byte,
    output logic       byte_valid,
    output logic       token_last,
    output logic       run_last,
    output logic       truncated
);

    q_status_t q_status;
    logic      push;
    cmd_t      push_cmd;
    logic      pop;
    cmd_t      head_cmd;

    // byte classification
    mtt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .in_byte   (in_byte),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // command queue
    mtt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    // buffer and emission
    mtt_back #(
        .MAX_TOKEN (MAX_TOKEN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .q_empty    (q_status.empty),
        .pop        (pop),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .token_kind (token_kind),
        .token_byte (token_byte),
        .byte_valid (byte_valid),
        .token_last (token_last),
        .run_last   (run_last),
        .truncated  (truncated)
    );

endmodule
